@@ rtl/core/bis_pkg.sv @@
`timescale 1ns / 1ps
package bis_pkg;

  // Field widths fixed by the item format
  localparam int KEY_W = 27;
  localparam int VOL_W = 32;
  localparam int POS_W = 12;
  localparam int IDX_W = 12;
  localparam int CNT_W = 13;

  // Reset value of the entry count register
  localparam logic [CNT_W-1:0] COUNT_RESET = 13'd4096;

  // Input item commands
  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_SEARCH = 1'b1;

  // Configuration register indexes
  localparam logic REG_ENTRY_COUNT = 1'b0;

  // Table read address selects
  localparam logic [2:0] RD_LO  = 3'd0;
  localparam logic [2:0] RD_HI  = 3'd1;
  localparam logic [2:0] RD_NX  = 3'd2;
  localparam logic [2:0] RD_JMP = 3'd3;
  localparam logic [2:0] RD_POS = 3'd4;

  // Controller to datapath commands
  typedef struct packed {
    logic       load;
    logic       start;
    logic       lat_klo;
    logic       lat_khi;
    logic       mul;
    logic       div_init;
    logic       div_step;
    logic       set_next;
    logic       sq_init;
    logic       sq_step;
    logic       jmp_add;
    logic       narrow;
    logic       scan_init;
    logic       scan_inc;
    logic       pos_lo;
    logic       pos_nx;
    logic       lat_vol;
    logic       set_miss;
    logic       out_load;
    logic [2:0] rd_sel;
  } bis_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic empty;
    logic out_rng;
    logic ends_eq;
    logic key_eq_lo;
    logic tiny_span;
    logic div_last;
    logic nx_eq;
    logic sq_last;
    logic in_lim;
    logic jmp_go;
    logic scan_eq;
    logic scan_last;
  } bis_stat_t;

endpackage

@@ rtl/core/bis_dp.sv @@
`timescale 1ns / 1ps
module bis_dp #(
  parameter int TABLE_DEPTH = 4096
) (
  input  logic                          clk,
  input  bis_pkg::bis_cmd_t             cmd_i,
  output bis_pkg::bis_stat_t            stat,
  input  logic [bis_pkg::CNT_W-1:0]     entry_count,
  input  logic [bis_pkg::IDX_W-1:0]     entry_index,
  input  logic [bis_pkg::KEY_W-1:0]     entry_key,
  input  logic [bis_pkg::VOL_W-1:0]     entry_volume,
  output logic                          found,
  output logic [bis_pkg::POS_W-1:0]     position,
  output logic [bis_pkg::VOL_W-1:0]     volume
);

  localparam int AW  = $clog2(TABLE_DEPTH);
  localparam int DW  = AW + 1;
  localparam int KW  = bis_pkg::KEY_W;
  localparam int VW  = bis_pkg::VOL_W;
  localparam int PW  = AW + KW;
  localparam int RW  = AW / 2 + 1;
  localparam int SQW = 2 * RW;
  localparam int XW  = ((AW > bis_pkg::IDX_W) ? AW : bis_pkg::IDX_W) + 1;
  localparam int CW  = ((AW + 1 > bis_pkg::CNT_W) ? AW + 1 : bis_pkg::CNT_W) + 1;
  localparam int CTW = $clog2(AW + 2);

  logic [KW-1:0] key_mem [TABLE_DEPTH];
  logic [VW-1:0] vol_mem [TABLE_DEPTH];
  logic [KW-1:0] kq;
  logic [VW-1:0] vq;
  logic [AW-1:0] rd_addr;

  logic [KW-1:0]  skey, klo, khi, dvs;
  logic [AW-1:0]  lo, hi, nx, pos;
  logic [PW-1:0]  prod;
  logic [KW-1:0]  rem;
  logic [AW:0]    quot;
  logic [CTW-1:0] divcnt;
  logic [RW-1:0]  root, sq_bit;
  logic [DW-1:0]  d;
  logic           up, empty;
  logic           res_found;
  logic [AW-1:0]  res_pos;
  logic [VW-1:0]  res_vol;

  logic [XW-1:0]  idx_x;
  logic [CW-1:0]  cnt_x;
  logic [AW:0]    n;
  logic [KW:0]    rem2;
  logic           qbit;
  logic [RW-1:0]  trial;
  logic [SQW-1:0] trial_sq;
  logic [AW:0]    size;
  logic [AW-1:0]  lim;
  logic [AW-1:0]  jaddr;
  logic [DW-1:0]  d_back;

  // Table write on load, registered read for search
  assign idx_x = XW'(entry_index);
  always_ff @(posedge clk) begin
    if (cmd_i.load && (idx_x < XW'(TABLE_DEPTH))) begin
      key_mem[idx_x[AW-1:0]] <= entry_key;
      vol_mem[idx_x[AW-1:0]] <= entry_volume;
    end
  end
  always_ff @(posedge clk) begin
    kq <= key_mem[rd_addr];
    vq <= vol_mem[rd_addr];
  end

  // Searched count saturates at the table depth
  assign cnt_x = CW'(entry_count);
  assign n = (cnt_x > CW'(TABLE_DEPTH)) ? (AW + 1)'(TABLE_DEPTH) : (AW + 1)'(cnt_x);

  // Division step, square root trial and jump limits
  assign rem2     = {rem, quot[AW]};
  assign qbit     = rem2 >= {1'b0, dvs};
  assign trial    = root | sq_bit;
  assign trial_sq = SQW'(trial) * SQW'(trial);
  assign size     = {1'b0, hi} - {1'b0, lo} + (AW + 1)'(1);
  assign lim      = up ? (hi - nx) : (nx - lo);
  assign jaddr    = up ? (nx + d[AW-1:0]) : (nx - d[AW-1:0]);
  assign d_back   = d - DW'(root);

  always_comb begin
    unique case (cmd_i.rd_sel)
      bis_pkg::RD_LO:  rd_addr = lo;
      bis_pkg::RD_HI:  rd_addr = hi;
      bis_pkg::RD_NX:  rd_addr = nx;
      bis_pkg::RD_JMP: rd_addr = jaddr;
      default:         rd_addr = pos;
    endcase
  end

  // Status to the controller
  assign stat.empty     = empty;
  assign stat.out_rng   = (skey < klo) || (skey > khi);
  assign stat.ends_eq   = klo == khi;
  assign stat.key_eq_lo = skey == klo;
  assign stat.tiny_span = (hi - lo) <= AW'(2);
  assign stat.div_last  = divcnt == '0;
  assign stat.nx_eq     = kq == skey;
  assign stat.sq_last   = sq_bit[0];
  assign stat.in_lim    = d <= DW'(lim);
  assign stat.jmp_go    = up ? (skey > kq) : (skey < kq);
  assign stat.scan_eq   = kq == skey;
  assign stat.scan_last = nx == hi;

  // Interval, interpolation and jump registers
  always_ff @(posedge clk) begin
    if (cmd_i.start) begin
      skey  <= entry_key;
      lo    <= '0;
      hi    <= AW'(n - (AW + 1)'(1));
      empty <= n == '0;
    end
    if (cmd_i.lat_klo) klo <= kq;
    if (cmd_i.lat_khi) khi <= kq;
    if (cmd_i.mul) begin
      prod <= PW'(hi - lo) * PW'(skey - klo);
      dvs  <= khi - klo;
    end
    if (cmd_i.div_init) begin
      rem    <= KW'(prod[PW-1:AW+1]);
      quot   <= prod[AW:0];
      divcnt <= CTW'(AW);
    end
    if (cmd_i.div_step) begin
      rem    <= qbit ? KW'(rem2 - {1'b0, dvs}) : KW'(rem2);
      quot   <= {quot[AW-1:0], qbit};
      divcnt <= divcnt - CTW'(1);
    end
    if (cmd_i.set_next) nx <= lo + quot[AW-1:0];
    if (cmd_i.sq_init) begin
      up     <= skey > kq;
      root   <= '0;
      sq_bit <= {1'b1, {(RW-1){1'b0}}};
    end
    if (cmd_i.sq_step) begin
      if (trial_sq <= SQW'(size)) begin
        root <= trial;
        if (sq_bit[0]) d <= DW'(trial);
      end else if (sq_bit[0]) begin
        d <= DW'(root);
      end
      sq_bit <= sq_bit >> 1;
    end
    if (cmd_i.jmp_add) d <= d + DW'(root);
    if (cmd_i.narrow) begin
      if (up) begin
        lo <= nx + d_back[AW-1:0];
        if (d < DW'(lim)) hi <= nx + d[AW-1:0];
      end else begin
        hi <= nx - d_back[AW-1:0];
        if (d < DW'(lim)) lo <= nx - d[AW-1:0];
      end
    end
    if (cmd_i.scan_init) nx <= lo;
    if (cmd_i.scan_inc)  nx <= nx + AW'(1);
    if (cmd_i.pos_lo)    pos <= lo;
    if (cmd_i.pos_nx)    pos <= nx;
  end

  // Result and output registers
  always_ff @(posedge clk) begin
    if (cmd_i.lat_vol) begin
      res_found <= 1'b1;
      res_pos   <= pos;
      res_vol   <= vq;
    end
    if (cmd_i.set_miss) begin
      res_found <= 1'b0;
      res_pos   <= '0;
      res_vol   <= '0;
    end
    if (cmd_i.out_load) begin
      found    <= res_found;
      position <= bis_pkg::POS_W'(res_pos);
      volume   <= res_vol;
    end
  end

endmodule

@@ rtl/core/bis_ctrl.sv @@
`timescale 1ns / 1ps
module bis_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                cmd,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  bis_pkg::bis_stat_t  stat,
  output bis_pkg::bis_cmd_t   cmd_o
);

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_INIT = 5'd1;
  localparam logic [4:0] S_RLO  = 5'd2;
  localparam logic [4:0] S_RHI  = 5'd3;
  localparam logic [4:0] S_CHK  = 5'd4;
  localparam logic [4:0] S_DEC  = 5'd5;
  localparam logic [4:0] S_MUL  = 5'd6;
  localparam logic [4:0] S_DIV  = 5'd7;
  localparam logic [4:0] S_NXT  = 5'd8;
  localparam logic [4:0] S_RNX  = 5'd9;
  localparam logic [4:0] S_CNX  = 5'd10;
  localparam logic [4:0] S_SQ   = 5'd11;
  localparam logic [4:0] S_JMP  = 5'd12;
  localparam logic [4:0] S_JCK  = 5'd13;
  localparam logic [4:0] S_NAR  = 5'd14;
  localparam logic [4:0] S_SREQ = 5'd15;
  localparam logic [4:0] S_SCK  = 5'd16;
  localparam logic [4:0] S_HIT  = 5'd17;
  localparam logic [4:0] S_HV   = 5'd18;
  localparam logic [4:0] S_MISS = 5'd19;
  localparam logic [4:0] S_DONE = 5'd20;

  logic [4:0] state, state_next;
  logic       out_valid_next;
  logic       in_xfer;

  assign in_stall = state != S_IDLE;
  assign in_xfer  = in_valid && !in_stall;

  // Sequence one load or search through the datapath
  always_comb begin
    state_next = state;
    cmd_o      = '0;
    cmd_o.rd_sel = bis_pkg::RD_LO;
    unique case (state)
      S_IDLE: begin
        if (in_xfer) begin
          if (cmd == bis_pkg::CMD_SEARCH) begin
            cmd_o.start = 1'b1;
            state_next  = S_INIT;
          end else begin
            cmd_o.load = 1'b1;
          end
        end
      end
      S_INIT: state_next = stat.empty ? S_MISS : S_RLO;
      S_RLO: begin
        cmd_o.rd_sel = bis_pkg::RD_LO;
        state_next   = S_RHI;
      end
      S_RHI: begin
        cmd_o.rd_sel  = bis_pkg::RD_HI;
        cmd_o.lat_klo = 1'b1;
        state_next    = S_CHK;
      end
      S_CHK: begin
        cmd_o.lat_khi = 1'b1;
        state_next    = S_DEC;
      end
      S_DEC: begin
        priority if (stat.out_rng) begin
          state_next = S_MISS;
        end else if (stat.ends_eq) begin
          cmd_o.pos_lo = stat.key_eq_lo;
          state_next   = stat.key_eq_lo ? S_HIT : S_MISS;
        end else if (stat.tiny_span) begin
          cmd_o.scan_init = 1'b1;
          state_next      = S_SREQ;
        end else begin
          cmd_o.mul  = 1'b1;
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.div_init = 1'b1;
        state_next     = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (stat.div_last) state_next = S_NXT;
      end
      S_NXT: begin
        cmd_o.set_next = 1'b1;
        state_next     = S_RNX;
      end
      S_RNX: begin
        cmd_o.rd_sel = bis_pkg::RD_NX;
        state_next   = S_CNX;
      end
      S_CNX: begin
        if (stat.nx_eq) begin
          cmd_o.pos_nx = 1'b1;
          state_next   = S_HIT;
        end else begin
          cmd_o.sq_init = 1'b1;
          state_next    = S_SQ;
        end
      end
      S_SQ: begin
        cmd_o.sq_step = 1'b1;
        if (stat.sq_last) state_next = S_JMP;
      end
      S_JMP: begin
        cmd_o.rd_sel = bis_pkg::RD_JMP;
        state_next   = stat.in_lim ? S_JCK : S_NAR;
      end
      S_JCK: begin
        if (stat.jmp_go) begin
          cmd_o.jmp_add = 1'b1;
          state_next    = S_JMP;
        end else begin
          state_next = S_NAR;
        end
      end
      S_NAR: begin
        cmd_o.narrow = 1'b1;
        state_next   = S_RLO;
      end
      S_SREQ: begin
        cmd_o.rd_sel = bis_pkg::RD_NX;
        state_next   = S_SCK;
      end
      S_SCK: begin
        priority if (stat.scan_eq) begin
          cmd_o.pos_nx = 1'b1;
          state_next   = S_HIT;
        end else if (stat.scan_last) begin
          state_next = S_MISS;
        end else begin
          cmd_o.scan_inc = 1'b1;
          state_next     = S_SREQ;
        end
      end
      S_HIT: begin
        cmd_o.rd_sel = bis_pkg::RD_POS;
        state_next   = S_HV;
      end
      S_HV: begin
        cmd_o.lat_vol = 1'b1;
        state_next    = S_DONE;
      end
      S_MISS: begin
        cmd_o.set_miss = 1'b1;
        state_next     = S_DONE;
      end
      S_DONE: begin
        if (!out_valid || !out_stall) begin
          cmd_o.out_load = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Hold the output transfer until the receiver takes it
  assign out_valid_next = cmd_o.out_load || (out_valid && out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

@@ rtl/core/binary_interpolation_search.sv @@
`timescale 1ns / 1ps
// Binary interpolation search over a loaded table of ascending keys.
// Input channel (in_valid/in_stall): cmd 0 loads entry_key and entry_volume
// at entry_index and gives no result; cmd 1 searches for
// entry_key among the first entry_count entries. One item is worked on at a
// time; in_stall stays high until the search result sits in the output
// register.
// Output channel (out_valid/out_stall): one transfer per search with found,
// position and volume (position and volume are 0 when the key is absent).
// A held result does not block the next input item.
// A search round runs the serial divider (one quotient bit a cycle) and the
// serial square root, which set most of its time, then the jump steps. An
// interval of at most three entries is scanned one entry at a time.
// APB port: entry_count at address 0, reset to 4096, to be written only while
// idle by the user (the block does not enforce this). Reset (rst, synchronous)
// clears the controller and output valid; the table holds no data until loaded.
module binary_interpolation_search #(
  parameter int TABLE_DEPTH = 4096
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       cmd,
  input  logic [bis_pkg::IDX_W-1:0]  entry_index,
  input  logic [bis_pkg::KEY_W-1:0]  entry_key,
  input  logic [bis_pkg::VOL_W-1:0]  entry_volume,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       found,
  output logic [bis_pkg::POS_W-1:0]  position,
  output logic [bis_pkg::VOL_W-1:0]  volume,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [2:0]                 paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  logic [bis_pkg::CNT_W-1:0] entry_count;
  bis_pkg::bis_cmd_t         cmd_w;
  bis_pkg::bis_stat_t        stat_w;

  // Configuration register
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= bis_pkg::COUNT_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == bis_pkg::REG_ENTRY_COUNT)) begin
      entry_count <= pwdata[bis_pkg::CNT_W-1:0];
    end
  end
  assign prdata = (paddr[2] == bis_pkg::REG_ENTRY_COUNT) ? 32'(entry_count) : '0;

  bis_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .cmd       (cmd),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat_w),
    .cmd_o     (cmd_w)
  );

  bis_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk          (clk),
    .cmd_i        (cmd_w),
    .stat         (stat_w),
    .entry_count  (entry_count),
    .entry_index  (entry_index),
    .entry_key    (entry_key),
    .entry_volume (entry_volume),
    .found        (found),
    .position     (position),
    .volume       (volume)
  );

endmodule
